FILE: src/frame_difference_spot_detector_core_macros.svh
// Assertion macros of the frame difference spot detector RTL, used by fdsd_pipe.
// Expects signals named clock and reset in the module that uses them.
`ifndef FRAME_DIFFERENCE_SPOT_DETECTOR_CORE_MACROS_SVH
`define FRAME_DIFFERENCE_SPOT_DETECTOR_CORE_MACROS_SVH

// check outside reset
`define FDSD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check at every edge, reset included
`define FDSD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: src/fdsd_pkg.sv
// Types and constants of the frame difference spot detector.
// No dependencies; used by every module of the block.
package fdsd_pkg;

   localparam int PIX_W      = 8;
   localparam int ROW_W      = 7;
   localparam int COL_W      = 8;
   localparam int CNT_W      = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [PIX_W-1:0] RST_JUMP_THR  = 8'd30;
   localparam logic [CNT_W-1:0] RST_FAIL_LIM  = 15'd1000;
   localparam logic [PIX_W-1:0] RST_PEAK_THR  = 8'd60;
   localparam logic [ROW_W-1:0] RST_FIRST_ROW = 7'd0;
   localparam logic [ROW_W-1:0] RST_END_ROW   = 7'd120;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_JUMP_THR  = 3'd0,
      CSR_FAIL_LIM  = 3'd1,
      CSR_PEAK_THR0 = 3'd2,
      CSR_PEAK_THR1 = 3'd3,
      CSR_FIRST_ROW = 3'd4,
      CSR_END_ROW   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] jump_thr;
      logic [CNT_W-1:0] fail_lim;
      logic [PIX_W-1:0] peak_thr0;
      logic [PIX_W-1:0] peak_thr1;
      logic [ROW_W-1:0] first_row;
      logic [ROW_W-1:0] end_row;
   } cfg_type;

   typedef struct packed {
      logic             en;
      logic [PIX_W-1:0] data;
   } store_wr_type;

endpackage

FILE: src/fdsd_csr.sv
// Configuration registers of the frame difference spot detector.
// Depends on fdsd_pkg.
module fdsd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [fdsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fdsd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output fdsd_pkg::cfg_type                cfg
);
   import fdsd_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.jump_thr  <= RST_JUMP_THR;
         cfg_ff.fail_lim  <= RST_FAIL_LIM;
         cfg_ff.peak_thr0 <= RST_PEAK_THR;
         cfg_ff.peak_thr1 <= RST_PEAK_THR;
         cfg_ff.first_row <= RST_FIRST_ROW;
         cfg_ff.end_row   <= RST_END_ROW;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_JUMP_THR:  cfg_ff.jump_thr  <= csr_wdata[PIX_W-1:0];
            CSR_FAIL_LIM:  cfg_ff.fail_lim  <= csr_wdata[CNT_W-1:0];
            CSR_PEAK_THR0: cfg_ff.peak_thr0 <= csr_wdata[PIX_W-1:0];
            CSR_PEAK_THR1: cfg_ff.peak_thr1 <= csr_wdata[PIX_W-1:0];
            CSR_FIRST_ROW: cfg_ff.first_row <= csr_wdata[ROW_W-1:0];
            CSR_END_ROW:   cfg_ff.end_row   <= csr_wdata[ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/fdsd_store.sv
// Previous frame store: one write and one registered read port, cleared after reset.
// Depends on fdsd_pkg.
module fdsd_store #(
   parameter int DEPTH  = 45120,
   parameter int ADDR_W = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [fdsd_pkg::PIX_W-1:0]   rd_data,
   input  fdsd_pkg::store_wr_type       wr,
   input  logic [ADDR_W-1:0]            wr_addr,
   output logic                         busy
);
   import fdsd_pkg::*;

   logic [PIX_W-1:0]  mem [DEPTH];
   logic [PIX_W-1:0]  rd_ff;
   logic              byp_ff;
   logic [PIX_W-1:0]  byp_data_ff;
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [PIX_W-1:0]  mem_wd;

   always_comb begin
      if (clr_busy_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = '0;
      end else begin
         mem_we = wr.en;
         mem_wa = wr_addr;
         mem_wd = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   // forward a write that lands on the address read in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         byp_ff      <= wr.en && (wr_addr == rd_addr);
         byp_data_ff <= wr.data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;
   assign busy    = clr_busy_ff;

endmodule

FILE: src/fdsd_pipe.sv
// Pixel pipeline: input stage, difference statistics, spot store and result register.
// Depends on fdsd_pkg and the assertion macro header.
`include "frame_difference_spot_detector_core_macros.svh"
module fdsd_pipe #(
   parameter int FRAME_ROWS  = 120,
   parameter int FRAME_COLS  = 188,
   parameter int NUM_CAMERAS = 2,
   parameter int ADDR_W      = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fdsd_pkg::cfg_type            cfg,
   input  logic                         acc,
   input  logic                         req_camera,
   input  logic [fdsd_pkg::PIX_W-1:0]   req_pixel,
   input  logic [fdsd_pkg::ROW_W-1:0]   req_row,
   input  logic [fdsd_pkg::COL_W-1:0]   req_col,
   input  logic                         req_last_pixel,
   output logic                         hold,
   output logic [ADDR_W-1:0]            rd_addr,
   input  logic [fdsd_pkg::PIX_W-1:0]   old_pixel,
   output fdsd_pkg::store_wr_type       wr,
   output logic [ADDR_W-1:0]            wr_addr,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_source_camera,
   output logic                         rsp_frame_accepted,
   output logic                         rsp_spot_found,
   output logic [fdsd_pkg::ROW_W-1:0]   rsp_spot_row,
   output logic [fdsd_pkg::COL_W-1:0]   rsp_spot_col,
   output logic [fdsd_pkg::PIX_W-1:0]   rsp_peak_difference,
   output logic [fdsd_pkg::CNT_W-1:0]   rsp_changed_count
);
   import fdsd_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_cam_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_last_ff;
   logic              s1_store_ff;
   logic [ADDR_W-1:0] s1_addr_ff;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PIX_W-1:0]  peak_ff, peak_in;
   logic [ROW_W-1:0]  prow_ff, prow_in;
   logic [COL_W-1:0]  pcol_ff, pcol_in;
   logic [ROW_W-1:0]  spot_row_ff [2];
   logic [COL_W-1:0]  spot_col_ff [2];

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_cam_ff;
   logic              rsp_accepted_ff;
   logic              rsp_found_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [PIX_W-1:0]  rsp_peak_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;

   logic              in_frame;
   logic              in_window;
   logic              s1_adv;
   logic              fire;
   logic [PIX_W-1:0]  diff;
   logic [PIX_W-1:0]  thr;
   logic              accepted;
   logic              found;

   assign in_frame = (32'(req_camera) < 32'(NUM_CAMERAS)) &&
                     (32'(req_row) < 32'(FRAME_ROWS)) &&
                     (32'(req_col) < 32'(FRAME_COLS));
   assign in_window = (req_row >= cfg.first_row) && (req_row < cfg.end_row);
   assign rd_addr = ADDR_W'((32'(req_camera) * 32'(FRAME_ROWS) + 32'(req_row))
                            * 32'(FRAME_COLS) + 32'(req_col));

   // hold a frame end while the previous result waits
   assign s1_adv = !(s1_last_ff && rsp_valid_ff && rsp_stall);
   assign fire   = s1_valid_ff && s1_adv;
   assign hold   = s1_valid_ff && !s1_adv;

   assign wr.en    = fire && s1_store_ff;
   assign wr.data  = s1_pix_ff;
   assign wr_addr  = s1_addr_ff;

   always_comb begin
      diff = (s1_pix_ff >= old_pixel) ? (s1_pix_ff - old_pixel) : (old_pixel - s1_pix_ff);
      cnt_in  = cnt_ff;
      peak_in = peak_ff;
      prow_in = prow_ff;
      pcol_in = pcol_ff;
      if (s1_store_ff) begin
         if ((diff > cfg.jump_thr) && (cnt_ff != CNT_MAX)) begin
            cnt_in = cnt_ff + 1'b1;
         end
         if (diff > peak_ff) begin
            peak_in = diff;
            prow_in = s1_row_ff;
            pcol_in = s1_col_ff;
         end
      end
      thr      = s1_cam_ff ? cfg.peak_thr1 : cfg.peak_thr0;
      accepted = cnt_in < cfg.fail_lim;
      found    = accepted && (peak_in >= thr);
   end

   always_comb begin
      s1_valid_in = acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      if (fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_cam_ff   <= req_camera;
         s1_pix_ff   <= req_pixel;
         s1_row_ff   <= req_row;
         s1_col_ff   <= req_col;
         s1_last_ff  <= req_last_pixel;
         s1_store_ff <= in_frame && in_window;
         s1_addr_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         peak_ff        <= '0;
         prow_ff        <= '0;
         pcol_ff        <= '0;
         spot_row_ff[0] <= '0;
         spot_row_ff[1] <= '0;
         spot_col_ff[0] <= '0;
         spot_col_ff[1] <= '0;
      end else if (fire) begin
         if (s1_last_ff) begin
            cnt_ff  <= '0;
            peak_ff <= '0;
            prow_ff <= '0;
            pcol_ff <= '0;
            if (found) begin
               spot_row_ff[s1_cam_ff] <= prow_in;
               spot_col_ff[s1_cam_ff] <= pcol_in;
            end
         end else begin
            cnt_ff  <= cnt_in;
            peak_ff <= peak_in;
            prow_ff <= prow_in;
            pcol_ff <= pcol_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && s1_last_ff) begin
         rsp_cam_ff      <= s1_cam_ff;
         rsp_accepted_ff <= accepted;
         rsp_found_ff    <= found;
         rsp_row_ff      <= found ? prow_in : spot_row_ff[s1_cam_ff];
         rsp_col_ff      <= found ? pcol_in : spot_col_ff[s1_cam_ff];
         rsp_peak_ff     <= peak_in;
         rsp_cnt_ff      <= cnt_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_source_camera   = rsp_cam_ff;
   assign rsp_frame_accepted  = rsp_accepted_ff;
   assign rsp_spot_found      = rsp_found_ff;
   assign rsp_spot_row        = rsp_row_ff;
   assign rsp_spot_col        = rsp_col_ff;
   assign rsp_peak_difference = rsp_peak_ff;
   assign rsp_changed_count   = rsp_cnt_ff;

   `FDSD_ASSERT_ALWAYS(a_rst_clears_rsp, reset |=> !rsp_valid_ff, "result valid after reset")
   `FDSD_ASSERT(a_found_accepted, rsp_valid_ff |-> (!rsp_found_ff || rsp_accepted_ff), "spot on rejected frame")
   `FDSD_ASSERT(a_rsp_from_last, $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff), "result without frame end")
   `FDSD_ASSERT(a_cnt_monotonic, !(s1_valid_ff && s1_last_ff) |=> cnt_ff >= $past(cnt_ff), "count dropped mid frame")

endmodule

FILE: src/frame_difference_spot_detector_core.sv
// Frame difference spot detector top level.
// Depends on fdsd_pkg, fdsd_csr, fdsd_store and fdsd_pipe.
//
// Usage:
//   req_* carries one pixel per transaction (camera, gray value, row, column,
//   last_pixel flag), accepted when req_valid is high and req_stall is low.
//   rsp_* carries one frame result per last_pixel transaction, taken when
//   rsp_valid is high and rsp_stall is low.
//   csr_* writes one configuration register per cycle with csr_wr_en high;
//   write only while no transaction is in flight.
//   Throughput: one pixel per clock while req_stall is low; the frame store does
//   one read and one write per cycle, with the write of a pixel forwarded to a
//   read of the same location issued in the same cycle.
//   Result path: the last pixel of a frame passes the input register, then the
//   frame result is registered in the result register and rsp_valid rises.
//   Reset: after reset the frame store is zeroed, one location per cycle, over all
//   NUM_CAMERAS * FRAME_ROWS * FRAME_COLS locations (45120 by default); req_stall
//   stays high during that pass.
//   Stall: a result held by rsp_stall keeps its payload; pixels keep flowing
//   until the next last_pixel sits in the input register, then req_stall rises.
module frame_difference_spot_detector_core #(
   parameter int FRAME_ROWS  = 120,
   parameter int FRAME_COLS  = 188,
   parameter int NUM_CAMERAS = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [fdsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fdsd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_camera,
   input  logic [fdsd_pkg::PIX_W-1:0]       req_pixel,
   input  logic [fdsd_pkg::ROW_W-1:0]       req_row,
   input  logic [fdsd_pkg::COL_W-1:0]       req_col,
   input  logic                             req_last_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_source_camera,
   output logic                             rsp_frame_accepted,
   output logic                             rsp_spot_found,
   output logic [fdsd_pkg::ROW_W-1:0]       rsp_spot_row,
   output logic [fdsd_pkg::COL_W-1:0]       rsp_spot_col,
   output logic [fdsd_pkg::PIX_W-1:0]       rsp_peak_difference,
   output logic [fdsd_pkg::CNT_W-1:0]       rsp_changed_count
);
   import fdsd_pkg::*;

   localparam int STORE_DEPTH = NUM_CAMERAS * FRAME_ROWS * FRAME_COLS;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   cfg_type               cfg;
   logic                  acc;
   logic                  pipe_hold;
   logic                  store_busy;
   logic [STORE_AW-1:0]   rd_addr;
   logic [STORE_AW-1:0]   wr_addr;
   logic [PIX_W-1:0]      old_pixel;
   store_wr_type          wr;

   assign req_stall = store_busy || pipe_hold;
   assign acc       = req_valid && !req_stall;

   fdsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fdsd_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (STORE_AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (acc),
      .rd_addr (rd_addr),
      .rd_data (old_pixel),
      .wr      (wr),
      .wr_addr (wr_addr),
      .busy    (store_busy)
   );

   fdsd_pipe #(
      .FRAME_ROWS  (FRAME_ROWS),
      .FRAME_COLS  (FRAME_COLS),
      .NUM_CAMERAS (NUM_CAMERAS),
      .ADDR_W      (STORE_AW)
   ) u_pipe (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .acc                 (acc),
      .req_camera          (req_camera),
      .req_pixel           (req_pixel),
      .req_row             (req_row),
      .req_col             (req_col),
      .req_last_pixel      (req_last_pixel),
      .hold                (pipe_hold),
      .rd_addr             (rd_addr),
      .old_pixel           (old_pixel),
      .wr                  (wr),
      .wr_addr             (wr_addr),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_source_camera   (rsp_source_camera),
      .rsp_frame_accepted  (rsp_frame_accepted),
      .rsp_spot_found      (rsp_spot_found),
      .rsp_spot_row        (rsp_spot_row),
      .rsp_spot_col        (rsp_spot_col),
      .rsp_peak_difference (rsp_peak_difference),
      .rsp_changed_count   (rsp_changed_count)
   );

endmodule

FILE: tb/tb_frame_difference_spot_detector_core.sv
`timescale 1ns / 1ps
// Self-checking testbench of frame_difference_spot_detector_core: a directed plan and
// random frames, every frame result checked against a behavioral model or a typed result.
// Depends on fdsd_pkg and the detector RTL.
module tb_frame_difference_spot_detector_core;
   import fdsd_pkg::*;

   localparam int FRAME_ROWS        = 120;
   localparam int FRAME_COLS        = 188;
   localparam int SETTLE_CYCLES     = 8;
   localparam int BACKLOG_CYCLES    = 400;
   localparam int RANDOM_PHASES     = 8;
   localparam int PHASE_PIXELS      = 210;

   typedef struct packed {
      logic             camera;
      logic [PIX_W-1:0] pixel;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last_pixel;
   } pixel_txn_type;

   typedef struct packed {
      logic             source_camera;
      logic             frame_accepted;
      logic             spot_found;
      logic [ROW_W-1:0] spot_row;
      logic [COL_W-1:0] spot_col;
      logic [PIX_W-1:0] peak_difference;
      logic [CNT_W-1:0] changed_count;
   } frame_result_type;

   typedef struct {
      bit                    is_csr;
      csr_index_type         csr_idx;
      logic [CSR_DATA_W-1:0] csr_value;
      pixel_txn_type         txn;
      bit                    typed;
      frame_result_type      result;
   } plan_row_type;

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  csr_wr_en          = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index          = '0;
   logic [CSR_DATA_W-1:0] csr_wdata          = '0;
   logic                  req_valid          = 1'b0;
   logic                  req_stall;
   logic                  req_camera         = 1'b0;
   logic [PIX_W-1:0]      req_pixel          = '0;
   logic [ROW_W-1:0]      req_row            = '0;
   logic [COL_W-1:0]      req_col            = '0;
   logic                  req_last_pixel     = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall          = 1'b0;
   logic                  rsp_source_camera;
   logic                  rsp_frame_accepted;
   logic                  rsp_spot_found;
   logic [ROW_W-1:0]      rsp_spot_row;
   logic [COL_W-1:0]      rsp_spot_col;
   logic [PIX_W-1:0]      rsp_peak_difference;
   logic [CNT_W-1:0]      rsp_changed_count;

   bit   [PIX_W-1:0] prior_frame [2][FRAME_ROWS][FRAME_COLS];
   cfg_type          cfg;
   logic [CNT_W-1:0] run_count;
   logic [PIX_W-1:0] run_peak;
   logic [ROW_W-1:0] run_peak_row;
   logic [COL_W-1:0] run_peak_col;
   logic [ROW_W-1:0] spot_row_of [2];
   logic [COL_W-1:0] spot_col_of [2];

   frame_result_type expected_results [$];
   plan_row_type     plan [$];
   int               error_count    = 0;
   bit               backlog_wanted = 1'b0;
   bit               backlog_done   = 1'b0;
   bit               send_idle_on   = 1'b1;
   bit               recv_idle_on   = 1'b1;
   int               send_mode_left = 0;
   int               recv_mode_left = 0;

   frame_difference_spot_detector_core #(
      .FRAME_ROWS (FRAME_ROWS),
      .FRAME_COLS (FRAME_COLS),
      .NUM_CAMERAS(2)
   ) dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_running_stats();
      run_count    = '0;
      run_peak     = '0;
      run_peak_row = '0;
      run_peak_col = '0;
   endfunction

   function automatic void reset_detector_model();
      cfg = '{RST_JUMP_THR, RST_FAIL_LIM, RST_PEAK_THR, RST_PEAK_THR, RST_FIRST_ROW,
              RST_END_ROW};
      clear_running_stats();
      spot_row_of = '{default: '0};
      spot_col_of = '{default: '0};
   endfunction

   // Returns 1 when the pixel closes a frame; r then holds the frame result.
   function automatic bit predict_frame_result(pixel_txn_type t, output frame_result_type r);
      logic [PIX_W-1:0] prior;
      logic [PIX_W-1:0] delta;
      logic [PIX_W-1:0] thr;
      bit               accepted;
      bit               found;
      r = '0;
      if (t.row < FRAME_ROWS && t.col < FRAME_COLS &&
          t.row >= cfg.first_row && t.row < cfg.end_row) begin
         prior = prior_frame[t.camera][t.row][t.col];
         delta = (t.pixel >= prior) ? t.pixel - prior : prior - t.pixel;
         prior_frame[t.camera][t.row][t.col] = t.pixel;
         if (delta > cfg.jump_thr && run_count != CNT_MAX) run_count++;
         if (delta > run_peak) begin
            run_peak     = delta;
            run_peak_row = t.row;
            run_peak_col = t.col;
         end
      end
      if (!t.last_pixel) return 1'b0;
      thr      = t.camera ? cfg.peak_thr1 : cfg.peak_thr0;
      accepted = run_count < cfg.fail_lim;
      found    = accepted && run_peak >= thr;
      if (found) begin
         spot_row_of[t.camera] = run_peak_row;
         spot_col_of[t.camera] = run_peak_col;
      end
      r = '{t.camera, accepted, found, spot_row_of[t.camera], spot_col_of[t.camera],
            run_peak, run_count};
      clear_running_stats();
      return 1'b1;
   endfunction

   function automatic int draw_gap(ref bit idle_on, ref int mode_left);
      if (mode_left == 0) begin
         idle_on   = $urandom_range(0, 3) != 0;
         mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      return idle_on ? $urandom_range(0, 6) : 0;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] draw_reg_value(csr_index_type idx);
      int pick;
      pick = $urandom_range(0, 7);
      case (idx)
         CSR_JUMP_THR, CSR_PEAK_THR0, CSR_PEAK_THR1:
            return CSR_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 120));
         CSR_FAIL_LIM:
            return CSR_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 32'h7FFF :
                               $urandom_range(1, 25));
         CSR_FIRST_ROW:
            return CSR_DATA_W'((pick == 0) ? 127 : (pick < 3) ? 0 : $urandom_range(0, 4));
         CSR_END_ROW:
            return CSR_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 127 : (pick < 4) ? 120 :
                               $urandom_range(3, 127));
         default:
            return '0;
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   function automatic void add_pixel(int cam, int pix, int row, int col, int last,
                                     int typed, frame_result_type r);
      plan_row_type e;
      e.is_csr    = 1'b0;
      e.csr_idx   = CSR_JUMP_THR;
      e.csr_value = '0;
      e.txn       = '{1'(cam), PIX_W'(pix), ROW_W'(row), COL_W'(col), 1'(last)};
      e.typed     = 1'(typed);
      e.result    = r;
      plan.push_back(e);
   endfunction

   function automatic void add_csr(csr_index_type idx, int value);
      plan_row_type e;
      e.is_csr    = 1'b1;
      e.csr_idx   = idx;
      e.csr_value = CSR_DATA_W'(value);
      e.txn       = '0;
      e.typed     = 1'b0;
      e.result    = '0;
      plan.push_back(e);
   endfunction

   function automatic void build_plan();
      frame_result_type none;
      none = '0;
      add_pixel(0,   0,   0,   0, 1, 1,
                frame_result_type'{1'b0, 1'b1, 1'b0, 7'd0, 8'd0, 8'd0, 15'd0});
      add_pixel(1, 255, 119, 187, 0, 0, none);
      add_pixel(1, 255, 127, 255, 1, 1,
                frame_result_type'{1'b1, 1'b1, 1'b1, 7'd119, 8'd187, 8'd255, 15'd1});
      add_pixel(0, 255,   0,   0, 0, 0, none);
      add_pixel(0,   0,   0,   0, 0, 0, none);
      add_pixel(0, 100, 120,   5, 0, 0, none);
      add_pixel(1,  77,   3, 200, 1, 0, none);
      add_pixel(0,  80,   5,  10, 0, 0, none);
      add_pixel(1,  90,   5,  10, 0, 0, none);
      add_pixel(0,  10,   6,  11, 1, 0, none);
      add_csr(CSR_JUMP_THR, 255);
      add_csr(CSR_FAIL_LIM, 0);
      add_csr(CSR_PEAK_THR0, 0);
      add_csr(CSR_PEAK_THR1, 255);
      add_pixel(1,   0, 119, 187, 1, 1,
                frame_result_type'{1'b1, 1'b0, 1'b0, 7'd0, 8'd0, 8'd255, 15'd0});
      add_csr(CSR_FAIL_LIM, 32'h7FFF);
      add_csr(CSR_FIRST_ROW, 10);
      add_csr(CSR_END_ROW, 5);
      add_pixel(0, 200,  10,   0, 0, 0, none);
      add_pixel(0,  33,   4,   1, 1, 1,
                frame_result_type'{1'b0, 1'b1, 1'b1, 7'd0, 8'd0, 8'd0, 15'd0});
      add_csr(CSR_JUMP_THR, 32'h7F00);
      add_csr(CSR_FIRST_ROW, 119);
      add_csr(CSR_END_ROW, 32'h7FFF);
      add_csr(CSR_PEAK_THR0, 255);
      add_csr(CSR_PEAK_THR1, 0);
      add_pixel(1,   1, 118,   0, 0, 0, none);
      add_pixel(1,   1, 119,   0, 0, 0, none);
      add_pixel(0,   0, 119, 187, 1, 0, none);
   endfunction

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_JUMP_THR:  cfg.jump_thr  = value[PIX_W-1:0];
         CSR_FAIL_LIM:  cfg.fail_lim  = value[CNT_W-1:0];
         CSR_PEAK_THR0: cfg.peak_thr0 = value[PIX_W-1:0];
         CSR_PEAK_THR1: cfg.peak_thr1 = value[PIX_W-1:0];
         CSR_FIRST_ROW: cfg.first_row = value[ROW_W-1:0];
         CSR_END_ROW:   cfg.end_row   = value[ROW_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_pixel(pixel_txn_type t, bit typed, frame_result_type typed_r);
      int               gap;
      frame_result_type r;
      gap = draw_gap(send_idle_on, send_mode_left);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_camera     <= t.camera;
      req_pixel      <= t.pixel;
      req_row        <= t.row;
      req_col        <= t.col;
      req_last_pixel <= t.last_pixel;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (predict_frame_result(t, r)) expected_results.push_back(typed ? typed_r : r);
   endtask

   task automatic send_random_frame(ref int sent);
      int               len;
      bit               cam;
      bit               mixed;
      pixel_txn_type    t;
      frame_result_type none;
      none  = '0;
      len   = $urandom_range(1, 30);
      cam   = 1'($urandom_range(0, 1));
      mixed = $urandom_range(0, 7) == 0;
      for (int k = 0; k < len; k++) begin
         case ($urandom_range(0, 9))
            0: begin
               t.row = ROW_W'($urandom_range(0, 127));
               t.col = COL_W'($urandom_range(0, 255));
            end
            1: begin
               t.row = ROW_W'($urandom_range(0, FRAME_ROWS - 1));
               t.col = COL_W'($urandom_range(0, FRAME_COLS - 1));
            end
            default: begin
               t.row = ROW_W'($urandom_range(0, 5));
               t.col = COL_W'($urandom_range(0, 5));
            end
         endcase
         case ($urandom_range(0, 7))
            0:       t.pixel = '0;
            1:       t.pixel = '1;
            default: t.pixel = PIX_W'($urandom_range(0, 255));
         endcase
         t.camera     = mixed ? 1'($urandom_range(0, 1)) : cam;
         t.last_pixel = (k == len - 1) || ($urandom_range(0, 39) == 0);
         send_pixel(t, 1'b0, none);
         sent++;
      end
   endtask

   initial begin
      bit            in_csr_run;
      int            phase_pixels;
      in_csr_run = 1'b0;
      reset_detector_model();
      build_plan();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            if (!in_csr_run) drain_results();
            write_reg(plan[i].csr_idx, plan[i].csr_value);
            in_csr_run = 1'b1;
         end else begin
            if (in_csr_run) csr_wr_en <= 1'b0;
            in_csr_run = 1'b0;
            send_pixel(plan[i].txn, plan[i].typed, plan[i].result);
         end
      end
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_results();
         for (int k = 0; k <= CSR_END_ROW; k++)
            write_reg(csr_index_type'(k), draw_reg_value(csr_index_type'(k)));
         csr_wr_en <= 1'b0;
         if (p == 2) backlog_wanted = 1'b1;
         phase_pixels = 0;
         while (phase_pixels < PHASE_PIXELS) send_random_frame(phase_pixels);
      end
      drain_results();
      if (error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int               gap;
      frame_result_type want;
      forever begin
         // hold off once for a long stretch so the detector backs up into its input
         if (backlog_wanted && !backlog_done) begin
            gap          = BACKLOG_CYCLES;
            backlog_done = 1'b1;
         end else begin
            gap = draw_gap(recv_idle_on, recv_mode_left);
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t ns: result transaction with none expected, camera %0d", $time,
                     rsp_source_camera);
         end else begin
            want = expected_results.pop_front();
            check_field("source_camera",   32'(want.source_camera),   32'(rsp_source_camera));
            check_field("frame_accepted",  32'(want.frame_accepted),  32'(rsp_frame_accepted));
            check_field("spot_found",      32'(want.spot_found),      32'(rsp_spot_found));
            check_field("spot_row",        32'(want.spot_row),        32'(rsp_spot_row));
            check_field("spot_col",        32'(want.spot_col),        32'(rsp_spot_col));
            check_field("peak_difference", 32'(want.peak_difference),
                        32'(rsp_peak_difference));
            check_field("changed_count",   32'(want.changed_count),   32'(rsp_changed_count));
         end
      end
   end

   initial begin
      #1_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/fdsd_pkg.sv
src/fdsd_csr.sv
src/fdsd_store.sv
src/fdsd_pipe.sv
src/frame_difference_spot_detector_core.sv
tb/tb_frame_difference_spot_detector_core.sv
